// ===== hw/rtl/gmf_pkg.sv =====
// ----------------------------------------------------------------------------
// gmf_pkg
// Shared types and constants of the 4x4 grayscale median filter.
// ----------------------------------------------------------------------------
package gmf_pkg;

  typedef logic [15:0][7:0] pix16_t;

  typedef struct packed {
    logic       interior;
    logic [7:0] border;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } gmf_side_t;

  localparam int unsigned SORT_LAYERS = 10;
  localparam int unsigned SORT_STAGES = SORT_LAYERS / 2;
  localparam int unsigned SORT_K [SORT_LAYERS] = '{2, 4, 4, 8, 8, 8, 16, 16, 16, 16};
  localparam int unsigned SORT_J [SORT_LAYERS] = '{1, 2, 1, 4, 2, 1, 8, 4, 2, 1};

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int unsigned CFG_BITS  = 11;
  localparam int unsigned SIZE_BITS = 13;
  localparam int unsigned MIN_SIZE  = 4;

endpackage

// ===== hw/rtl/gmf_ram.sv =====
// ----------------------------------------------------------------------------
// gmf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/gmf_sort16.sv =====
// ----------------------------------------------------------------------------
// gmf_sort16
// Pipelined bitonic sorting network over 16 pixels, two layers per stage,
// giving the truncated mean of the two middle values.
// ----------------------------------------------------------------------------
module gmf_sort16
  import gmf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  gmf_side_t in_side,
  input  pix16_t    in_vals,
  output logic      out_valid,
  output gmf_side_t out_side,
  output logic [7:0] median
);

  function automatic pix16_t sort_layer(pix16_t v, int unsigned k, int unsigned j);
    pix16_t      r;
    int unsigned p;
    logic        up;
    r = v;
    for (int unsigned i = 0; i < 16; i++) begin
      p = i ^ j;
      if (p > i) begin
        up = ((i & k) == 0);
        if ((v[i] > v[p]) == up) begin
          r[i] = v[p];
          r[p] = v[i];
        end
      end
    end
    return r;
  endfunction

  pix16_t    stage [SORT_STAGES];
  pix16_t    stage_next [SORT_STAGES];
  gmf_side_t side [SORT_STAGES];
  logic [SORT_STAGES-1:0] valid;

  always_comb begin
    for (int unsigned s = 0; s < SORT_STAGES; s++) begin
      stage_next[s] = sort_layer(sort_layer((s == 0) ? in_vals : stage[s-1],
                                            SORT_K[2*s], SORT_J[2*s]),
                                 SORT_K[2*s+1], SORT_J[2*s+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[SORT_STAGES-2:0], in_valid};
    end
    if (en) begin
      side[0] <= in_side;
      for (int unsigned s = 0; s < SORT_STAGES; s++) begin
        stage[s] <= stage_next[s];
        if (s > 0) begin
          side[s] <= side[s-1];
        end
      end
    end
  end

  assign out_valid = valid[SORT_STAGES-1];
  assign out_side  = side[SORT_STAGES-1];
  assign median    = 8'((9'(stage[SORT_STAGES-1][7]) + 9'(stage[SORT_STAGES-1][8])) >> 1);

endmodule

// ===== hw/rtl/gray_median_filter_4x4.sv =====
// ----------------------------------------------------------------------------
// gray_median_filter_4x4
// 4x4 median filter over one 8-bit grayscale frame in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ group with tuser low; a word with tuser high is a
// flush and only counts once the whole frame has arrived, when it drains one
// pending result. Once the frame is in, every word drains one result. Each
// result carries the pixel, its row and column, and tlast on the frame's
// last pixel. Interior pixels get the median of their 4x4 window, border
// pixels pass through.
// One word is taken per cycle unless the output stalls. A result passes the
// s1 registers, the window and s2 registers, the sort stages and the output
// registers; results trail the pixels by width+1 words, so width+1 extra words
// drain a frame. The previous three rows live in one RAM of MAX_WIDTH words of
// three pixels, read once per accepted word and written once per pixel; the
// median comes from a five-stage sorting network. When a result waits with
// m_tready low, the whole pipeline holds and s_tready drops.
// Reset clears the counters and sets width and height to 1024; the RAM is
// not cleared. A register write restarts the frame.
// ----------------------------------------------------------------------------
module gray_median_filter_4x4
  import gmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // pixel_in
  input  logic [0:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_out, out_row, out_col, zero padding
  output logic        m_tlast,   // frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ORW = $clog2(MAX_HEIGHT);
  localparam int unsigned IRW = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned WX  = WW + 1;
  localparam int unsigned HX  = HW + 1;

  logic [CFG_BITS-1:0] width_reg;
  logic [CFG_BITS-1:0] height_reg;
  logic [WW-1:0]       w;
  logic [HW-1:0]       h;
  logic                cfg_wr;

  logic [CW-1:0]  in_col;
  logic [IRW-1:0] in_row;
  logic [CW-1:0]  out_col;
  logic [ORW-1:0] out_row;
  logic           done;

  logic en, accept, act, emit, in_col_last, out_col_last, last, interior;

  logic        s1_valid, s1_emit, s1_wr;
  logic [7:0]  s1_pix;
  logic [CW-1:0] s1_col;
  gmf_side_t   s1_side;
  logic [23:0] ram_rdata;

  logic [7:0]  win [4][4];
  logic        s2_valid;
  gmf_side_t   s2_side;
  gmf_side_t   sort_in_side;
  pix16_t      sort_in_vals;

  logic        sort_valid;
  gmf_side_t   sort_side;
  logic [7:0]  median;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= CFG_BITS'(1024);
      height_reg <= CFG_BITS'(1024);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        width_reg <= pwdata[CFG_BITS-1:0];
      end else begin
        height_reg <= pwdata[CFG_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (SIZE_BITS'(width_reg) < SIZE_BITS'(MIN_SIZE)) begin
      w = WW'(MIN_SIZE);
    end else if (SIZE_BITS'(width_reg) > SIZE_BITS'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_reg);
    end
    if (SIZE_BITS'(height_reg) < SIZE_BITS'(MIN_SIZE)) begin
      h = HW'(MIN_SIZE);
    end else if (SIZE_BITS'(height_reg) > SIZE_BITS'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(height_reg);
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;
  assign act      = accept && (done || (s_tuser[0] == CMD_PIXEL));
  assign emit     = done || (in_row >= IRW'(2)) || ((in_row == IRW'(1)) && (in_col != '0));

  assign in_col_last  = (WW'(in_col) + WW'(1)) == w;
  assign out_col_last = (WW'(out_col) + WW'(1)) == w;
  assign last         = out_col_last && ((HW'(out_row) + HW'(1)) == h);
  assign interior     = (out_row >= ORW'(2)) && ((HX'(out_row) + HX'(3)) <= HX'(h)) &&
                        (out_col >= CW'(2)) && ((WX'(out_col) + WX'(3)) <= WX'(w));

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      done    <= 1'b0;
    end else if (act) begin
      if (in_col_last) begin
        in_col <= '0;
        in_row <= in_row + IRW'(1);
        if (!done && ((IRW'(in_row) + IRW'(1)) >= IRW'(h))) begin
          done <= 1'b1;
        end
      end else begin
        in_col <= in_col + CW'(1);
      end
      if (emit) begin
        if (out_col_last) begin
          out_col <= '0;
          out_row <= out_row + ORW'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
        if (last) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
          done    <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= act;
      s2_valid <= s1_valid && s1_emit;
    end
    if (en && act) begin
      s1_emit           <= emit;
      s1_wr             <= !done;
      s1_pix            <= s_tdata;
      s1_col            <= in_col;
      s1_side.interior  <= interior;
      s1_side.border    <= '0;
      s1_side.row       <= 10'(out_row);
      s1_side.col       <= 10'(out_col);
      s1_side.last      <= last;
    end
    if (en && s1_valid) begin
      for (int unsigned c = 0; c < 3; c++) begin
        for (int unsigned r = 0; r < 4; r++) begin
          win[c][r] <= win[c+1][r];
        end
      end
      win[3][0] <= ram_rdata[7:0];
      win[3][1] <= ram_rdata[15:8];
      win[3][2] <= ram_rdata[23:16];
      win[3][3] <= s1_pix;
    end
    if (en) begin
      s2_side <= s1_side;
    end
  end

  gmf_ram #(
    .WIDTH(24),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (en && s1_valid && s1_wr),
    .waddr(s1_col),
    .wdata({s1_pix, ram_rdata[23:8]}),
    .re   (accept),
    .raddr(in_col),
    .rdata(ram_rdata)
  );

  always_comb begin
    sort_in_side        = s2_side;
    sort_in_side.border = win[2][2];
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned r = 0; r < 4; r++) begin
        sort_in_vals[r*4+c] = win[c][r];
      end
    end
  end

  gmf_sort16 u_sort (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s2_valid),
    .in_side  (sort_in_side),
    .in_vals  (sort_in_vals),
    .out_valid(sort_valid),
    .out_side (sort_side),
    .median   (median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= sort_valid;
    end
    if (en) begin
      m_tdata <= {4'b0, sort_side.col, sort_side.row,
                  sort_side.interior ? median : sort_side.border};
      m_tlast <= sort_side.last;
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (WW'(in_col) < w) && (WW'(out_col) < w))
    else $error("column counter out of range");

  a_done_rows: assert property (@(posedge clk) disable iff (rst)
    done |-> (in_row >= IRW'(h)))
    else $error("frame marked complete too early");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

endmodule

// ===== tb/tb_gray_median_filter_4x4.sv =====
// ----------------------------------------------------------------------------
// tb_gray_median_filter_4x4
// Self-checking testbench of the 4x4 grayscale median filter.
// ----------------------------------------------------------------------------
// Frames of several sizes are written through the APB port, streamed in raster
// order and drained with words of either command. A behavioral model of the
// window store and median predicts every output word, which a scoreboard
// compares field by field. Both stream sides idle at random, and the run also
// covers size clamping, early flushes and pixels sent while a frame drains.
// ----------------------------------------------------------------------------
module tb_gray_median_filter_4x4;
  import gmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] pix;
    logic [9:0] row;
    logic [9:0] col;
    logic       fend;
  } filt_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gray_median_filter_4x4 uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  filt_word_t  pending_pixels[$];
  logic [7:0]  pix_rows[4096];
  logic [10:0] width_reg = 11'd1024;
  logic [10:0] height_reg = 11'd1024;
  int unsigned in_row, in_col, out_row, out_col;
  bit          input_complete;
  bit          quiet;
  int          errors = 0;
  int unsigned cycles = 0;
  int unsigned sent_words = 0;

  function automatic int unsigned clamp_dim(logic [10:0] v);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > 1024) return 1024;
    return 32'(v);
  endfunction

  function automatic logic [7:0] window_median(int unsigned y, int unsigned x);
    logic [7:0] vals[16];
    logic [7:0] t;
    int n, i, j;
    n = 0;
    for (i = 0; i < 4; i++)
      for (j = 0; j < 4; j++) begin
        vals[n] = pix_rows[((y - 2 + i) & 3) * 1024 + (x - 2 + j)];
        n++;
      end
    for (i = 1; i < 16; i++) begin
      t = vals[i];
      j = i;
      while (j > 0 && vals[j - 1] > t) begin
        vals[j] = vals[j - 1];
        j--;
      end
      vals[j] = t;
    end
    return 8'((9'(vals[7]) + 9'(vals[8])) >> 1);
  endfunction

  function automatic void restart_frame();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
    input_complete = 0;
  endfunction

  function automatic void predict_filter(logic cmd, logic [7:0] pix);
    int unsigned w, h;
    bit emit;
    filt_word_t r;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    if (!input_complete && cmd == CMD_PIXEL) begin
      emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
      pix_rows[(in_row & 3) * 1024 + in_col] = pix;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) input_complete = 1;
      end
      if (!emit) return;
    end else if (!input_complete) begin
      return;
    end
    if (out_row >= 2 && out_row + 3 <= h && out_col >= 2 && out_col + 3 <= w)
      r.pix = window_median(out_row, out_col);
    else
      r.pix = pix_rows[(out_row & 3) * 1024 + out_col];
    r.row = out_row[9:0];
    r.col = out_col[9:0];
    r.fend = (out_row + 1 == h) && (out_col + 1 == w);
    pending_pixels = {pending_pixels, r};
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (r.fend) restart_frame();
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (cycles < 12) begin
      m_tready <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) < 70);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    filt_word_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected word, actual %h last %b", $time, m_tdata, m_tlast);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (m_tdata[7:0] !== e.pix || m_tdata[17:8] !== e.row ||
            m_tdata[27:18] !== e.col || m_tdata[31:28] !== 4'd0 || m_tlast !== e.fend) begin
          $display("%0t: expected pix %0d row %0d col %0d last %b, actual pix %0d row %0d col %0d last %b",
                   $time, e.pix, e.row, e.col, e.fend, m_tdata[7:0], m_tdata[17:8],
                   m_tdata[27:18], m_tlast);
          errors++;
        end
      end
    end
  end

  task automatic send_word(logic cmd, logic [7:0] pix);
    int unsigned g;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= pix;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    predict_filter(cmd, pix);
    sent_words++;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    s_tvalid <= 1'b0;
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(idx) << 2;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WIDTH) width_reg = value[10:0];
    else height_reg = value[10:0];
    restart_frame();
  endtask

  // Pixel styles: 0 random, 1 full-scale extremes, 2 narrow band, 3 flat.
  task automatic stream_frame(logic [31:0] w, logic [31:0] h, int style, int noise_pct);
    int unsigned n, npix;
    logic [7:0] base, p;
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    quiet = ($urandom_range(0, 3) == 0);
    npix = clamp_dim(w[10:0]) * clamp_dim(h[10:0]);
    base = 8'($urandom);
    n = 0;
    while (n < npix) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_word(CMD_FLUSH, 8'($urandom));
      end else begin
        case (style)
          1: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          2: p = base + 8'($urandom_range(0, 7));
          3: p = base;
          default: p = 8'($urandom);
        endcase
        send_word(CMD_PIXEL, p);
        n++;
      end
    end
    for (n = 0; n <= clamp_dim(w[10:0]); n++)
      send_word(1'($urandom_range(0, 1)), 8'($urandom));
    quiet = 0;
  endtask

  // The frame is left unfinished; the next register write restarts it.
  task automatic stream_partial(logic [31:0] w, logic [31:0] h, int unsigned count);
    int unsigned n;
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    for (n = 0; n < count; n++) send_word(CMD_PIXEL, 8'($urandom));
  endtask

  task automatic test_smallest_frames();
    stream_frame(4, 4, 1, 0);
    stream_frame(5, 5, 0, 0);
  endtask

  task automatic test_size_clamping();
    stream_frame(0, 3, 0, 0);
    stream_partial(1, 2047, 48);
    stream_partial(2047, 4, 1060);
  endtask

  task automatic test_flush_handling();
    stream_frame(6, 5, 0, 30);
    stream_frame(4, 6, 2, 15);
  endtask

  task automatic test_restart_mid_frame();
    int i;
    write_reg(REG_WIDTH, 7);
    write_reg(REG_HEIGHT, 6);
    for (i = 0; i < 17; i++) send_word(CMD_PIXEL, 8'($urandom));
    stream_frame(7, 6, 0, 0);
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int style;
    start = sent_words;
    while (sent_words - start < 200) begin
      style = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3);
      stream_frame($urandom_range(4, 14), $urandom_range(4, 12), style,
                   $urandom_range(0, 3) == 0 ? 10 : 0);
    end
  endtask

  initial begin
    quiet = 0;
    restart_frame();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_smallest_frames();
    test_size_clamping();
    test_flush_handling();
    test_restart_mid_frame();
    test_random_frames();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== gray_median_filter_4x4.f =====
hw/rtl/gmf_pkg.sv
hw/rtl/gmf_ram.sv
hw/rtl/gmf_sort16.sv
hw/rtl/gray_median_filter_4x4.sv
tb/tb_gray_median_filter_4x4.sv
